// ===== src/tgsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgsc_pkg
// Shared widths, codes, types and the quarter-wave sine table of the tone
// generator.
// ----------------------------------------------------------------------------
package tgsc_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_RATE     = 44100;

  localparam int FREQ_W   = 17;
  localparam int SAMPLE_W = 16;
  localparam int WAVE_W   = 2;
  localparam int STICK_W  = 8;
  localparam int ZSTEP_W  = 7;

  // phase step = floor(freq * 2^PHASE_BITS / PHASE_DEN), by reciprocal multiply
  localparam int PHASE_DEN = 10 * SAMPLE_RATE;
  localparam int DEN_W     = $clog2(PHASE_DEN + 1);
  localparam int RECIP_W   = PHASE_BITS + FREQ_W + 1 - $clog2(PHASE_DEN);
  localparam int WIDE_W    = PHASE_BITS + FREQ_W;
  localparam logic [127:0] RECIP_FULL =
    (128'd1 << (PHASE_BITS + FREQ_W)) / 128'(PHASE_DEN);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [FREQ_W-1:0] FREQ_RESET     = 17'd4400;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RESET = 17'd320;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RESET = 17'd70400;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic CFG_FREQ_MIN = 1'b0;
  localparam logic CFG_FREQ_MAX = 1'b1;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

  localparam logic [STICK_W-1:0] STICK_CENTER = 8'd128;
  localparam logic [STICK_W-1:0] ZONE_EDGE [5] = '{8'd30, 8'd70, 8'd100, 8'd112, 8'd125};
  localparam logic [ZSTEP_W-1:0] ZONE_STEP [6] =
    '{7'd0, 7'd1, 7'd5, 7'd10, 7'd40, 7'd80};

  localparam logic signed [SAMPLE_W-1:0] SQUARE_LEVEL = 16'sd6553;
  localparam logic signed [SAMPLE_W-1:0] TRI_PEAK     = 16'sd16383;
  localparam logic [14:0]                TRI_SCALE    = 15'd32766;

  localparam int SINE_W  = 15;
  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int TIDX_W  = SINE_TABLE_BITS - 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_PEAK   = 64'd32766;
  localparam logic [63:0] TAYLOR_DIV [8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [SINE_W-1:0] sine_tab_t [0:QUARTER];

  typedef struct packed {
    logic                  is_sample;
    logic [FREQ_W-1:0]     freq;
    logic [WAVE_W-1:0]     wave;
    logic [PHASE_BITS-1:0] step;
  } tgsc_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_min;
    logic [FREQ_W-1:0] freq_max;
  } tgsc_cfg_t;

  // Q30 Taylor series of sin over the first quadrant, rounded to the peak
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] v;
    longint      sum;
    for (int k = 0; k <= QUARTER; k++) begin
      x   = (64'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[n-1];
        if (n[0]) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * SINE_PEAK + (64'd1 << 29)) >> 30;
      if (v > SINE_PEAK) begin
        v = SINE_PEAK;
      end
      tab[k] = SINE_W'(v);
    end
    return tab;
  endfunction

endpackage

// ===== src/tgsc_front.sv =====
// ----------------------------------------------------------------------------
// tgsc_front
// Accepts items, applies control polls to frequency and waveform, and works
// out the phase step of each item in a short fixed pipeline.
// ----------------------------------------------------------------------------
module tgsc_front import tgsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_operation,
  input  logic [STICK_W-1:0] in_stick_y,
  input  logic               in_cycle_button,
  input  tgsc_cfg_t          cfg,
  input  logic [LVL_W-1:0]   fifo_level,
  output logic               fifo_wr,
  output tgsc_item_t         fifo_item
);

  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [WAVE_W-1:0] wave_r, wave_nxt;
  logic              btn_prev_r;

  logic                  p0_v_r, p1_v_r, p2_v_r;
  logic                  p0_is_r, p1_is_r, p2_is_r;
  logic [FREQ_W-1:0]     p0_freq_r, p1_freq_r, p2_freq_r;
  logic [WAVE_W-1:0]     p0_wave_r, p1_wave_r, p2_wave_r;
  logic [FREQ_W-1:0]     p1_fmod_r, p2_fmod_r;
  logic [PHASE_BITS-1:0] p1_q0_r, p2_q0_r;
  logic [WIDE_W-1:0]     p2_prod_r;

  logic                       accept;
  logic [LVL_W:0]             credit;
  logic                       raise;
  logic [STICK_W-1:0]         stick_dev;
  logic [ZSTEP_W-1:0]         zstep;
  logic signed [FREQ_W+1:0]   fsum;
  logic [FREQ_W-1:0]          fmod;
  logic [FREQ_W+RECIP_W-1:0]  mul1;
  logic [PHASE_BITS+DEN_W-1:0] mul2;
  logic [WIDE_W-1:0]          rem;

  // hold off pushes while the queue could not absorb everything in flight
  assign credit  = {1'b0, fifo_level} + (LVL_W+1)'(p0_v_r) + (LVL_W+1)'(p1_v_r)
                 + (LVL_W+1)'(p2_v_r);
  assign in_full = credit >= (LVL_W+1)'(FIFO_DEPTH);
  assign accept  = in_push & ~in_full;

  always_comb begin
    raise     = in_stick_y < STICK_CENTER;
    stick_dev = raise ? STICK_CENTER - in_stick_y : in_stick_y - STICK_CENTER;
    priority if (stick_dev < ZONE_EDGE[0]) zstep = ZONE_STEP[0];
    else if (stick_dev < ZONE_EDGE[1])     zstep = ZONE_STEP[1];
    else if (stick_dev < ZONE_EDGE[2])     zstep = ZONE_STEP[2];
    else if (stick_dev < ZONE_EDGE[3])     zstep = ZONE_STEP[3];
    else if (stick_dev < ZONE_EDGE[4])     zstep = ZONE_STEP[4];
    else                                   zstep = ZONE_STEP[5];

    fsum = raise ? $signed({2'b00, freq_r}) + $signed({{(FREQ_W+2-ZSTEP_W){1'b0}}, zstep})
                 : $signed({2'b00, freq_r}) - $signed({{(FREQ_W+2-ZSTEP_W){1'b0}}, zstep});

    // lower bound first; with crossed limits it wins only below freq_min
    priority if (fsum < $signed({2'b00, cfg.freq_min})) freq_nxt = cfg.freq_min;
    else if (fsum > $signed({2'b00, cfg.freq_max}))      freq_nxt = cfg.freq_max;
    else                                                 freq_nxt = FREQ_W'(fsum);

    wave_nxt = wave_r;
    if (in_cycle_button && !btn_prev_r) begin
      wave_nxt = (wave_r >= WAVE_TRIANGLE) ? WAVE_SINE : wave_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r     <= FREQ_RESET;
      wave_r     <= WAVE_SINE;
      btn_prev_r <= 1'b0;
    end else if (accept && in_operation == OP_POLL) begin
      freq_r     <= freq_nxt;
      wave_r     <= wave_nxt;
      btn_prev_r <= in_cycle_button;
    end
  end

  // stage 0: item record
  always_ff @(posedge clk) begin
    if (accept) begin
      p0_is_r   <= in_operation == OP_TICK;
      p0_freq_r <= (in_operation == OP_POLL) ? freq_nxt : freq_r;
      p0_wave_r <= (in_operation == OP_POLL) ? wave_nxt : wave_r;
    end
  end

  // stage 1: reduce modulo the denominator, multiply by the reciprocal
  always_comb begin
    if (32'(p0_freq_r) >= 32'(PHASE_DEN)) begin
      fmod = FREQ_W'(32'(p0_freq_r) - 32'(PHASE_DEN));
    end else begin
      fmod = p0_freq_r;
    end
    mul1 = (FREQ_W+RECIP_W)'(fmod) * (FREQ_W+RECIP_W)'(RECIP_M);
  end

  always_ff @(posedge clk) begin
    p1_is_r   <= p0_is_r;
    p1_freq_r <= p0_freq_r;
    p1_wave_r <= p0_wave_r;
    p1_fmod_r <= fmod;
    p1_q0_r   <= PHASE_BITS'(mul1 >> FREQ_W);
  end

  // stage 2: back-multiply the estimate
  assign mul2 = (PHASE_BITS+DEN_W)'(p1_q0_r) * (PHASE_BITS+DEN_W)'(PHASE_DEN);

  always_ff @(posedge clk) begin
    p2_is_r   <= p1_is_r;
    p2_freq_r <= p1_freq_r;
    p2_wave_r <= p1_wave_r;
    p2_fmod_r <= p1_fmod_r;
    p2_q0_r   <= p1_q0_r;
    p2_prod_r <= WIDE_W'(mul2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p0_v_r <= accept;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
    end
  end

  // estimate is at most one low: correct it with one compare
  assign rem = {p2_fmod_r, {PHASE_BITS{1'b0}}} - p2_prod_r;

  always_comb begin
    fifo_wr             = p2_v_r;
    fifo_item.is_sample = p2_is_r;
    fifo_item.freq      = p2_freq_r;
    fifo_item.wave      = p2_wave_r;
    fifo_item.step      = p2_q0_r + PHASE_BITS'(rem >= WIDE_W'(PHASE_DEN));
  end

endmodule

// ===== src/tgsc_fifo.sv =====
// ----------------------------------------------------------------------------
// tgsc_fifo
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tgsc_fifo import tgsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tgsc_item_t       wr_item,
  input  logic             rd_en,
  output tgsc_item_t       rd_item,
  output logic             empty,
  output logic [LVL_W-1:0] level
);

  tgsc_item_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] count_r;

  assign rd_item = mem_r[rd_ptr_r];
  assign empty   = count_r == '0;
  assign level   = count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + LVL_W'(wr_en) - LVL_W'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> count_r < LVL_W'(FIFO_DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("queue read while empty");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== src/tgsc_back.sv =====
// ----------------------------------------------------------------------------
// tgsc_back
// Runs the phase accumulator, shapes the waveform and holds the result word
// in an output register.
// ----------------------------------------------------------------------------
module tgsc_back import tgsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fifo_empty,
  input  tgsc_item_t                 fifo_item,
  output logic                       fifo_rd,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_is_sample,
  output logic [FREQ_W-1:0]          out_freq_now,
  output logic [WAVE_W-1:0]          out_waveform
);

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [PHASE_BITS-1:0]      phase_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       is_sample_r;
  logic [FREQ_W-1:0]          freq_now_r;
  logic [WAVE_W-1:0]          waveform_r;

  logic                        take;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [1:0]                  quad;
  logic [TIDX_W-2:0]           off;
  logic [TIDX_W-1:0]           tidx;
  logic [SINE_W-1:0]           sine_mag;
  logic signed [SAMPLE_W-1:0]  sine_val;
  logic [15:0]                 tri_u;
  logic [29:0]                 tri_prod;
  logic signed [SAMPLE_W-1:0]  tri_part;
  logic signed [SAMPLE_W-1:0]  tri_val;
  logic signed [SAMPLE_W-1:0]  wave_val;

  // advance whenever the output word is free or leaving
  assign take    = !fifo_empty && (!out_valid_r || out_pop);
  assign fifo_rd = take;

  always_comb begin
    idx      = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad     = idx[SINE_TABLE_BITS-1 -: 2];
    off      = idx[SINE_TABLE_BITS-3:0];
    tidx     = quad[0] ? TIDX_W'(QUARTER) - {1'b0, off} : {1'b0, off};
    sine_mag = SINE_TAB[tidx];
    sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    // falling half reuses the rising-half product of the low 15 bits
    tri_u    = phase_r[PHASE_BITS-1 -: 16];
    tri_prod = 30'(tri_u[14:0]) * 30'(TRI_SCALE);
    tri_part = $signed({1'b0, tri_prod[29:15]});
    tri_val  = tri_u[15] ? TRI_PEAK - tri_part : tri_part - TRI_PEAK;

    unique case (fifo_item.wave)
      WAVE_SINE:     wave_val = sine_val;
      WAVE_SQUARE:   wave_val = phase_r[PHASE_BITS-1] ? SQUARE_LEVEL : -SQUARE_LEVEL;
      WAVE_TRIANGLE: wave_val = tri_val;
      default:       wave_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && fifo_item.is_sample) begin
        phase_r <= phase_r + fifo_item.step;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r    <= fifo_item.is_sample ? wave_val : '0;
      is_sample_r <= fifo_item.is_sample;
      freq_now_r  <= fifo_item.freq;
      waveform_r  <= fifo_item.wave;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_sample    = sample_r;
  assign out_is_sample = is_sample_r;
  assign out_freq_now  = freq_now_r;
  assign out_waveform  = waveform_r;

endmodule

// ===== src/tone_generator_with_stick_control_top.sv =====
// ----------------------------------------------------------------------------
// tone_generator_with_stick_control_top
// Tone generator with stick frequency control and button waveform select.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, sustained while results are popped, and
// gives one result word per item in order. An item passes through the
// item record, the reciprocal multiply, the back-multiply and the
// correction into the 8-entry queue, and from the queue into the output
// register. Full rises once the queue plus the three front stages hold eight
// words, so a result side that stops popping backs up the input after nine
// words (those eight plus the one in the output register). Frequency limits
// are written on the cfg port, which is always ready; write them only while
// no items are in flight.
module tone_generator_with_stick_control_top import tgsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_operation,
  input  logic [STICK_W-1:0]         in_stick_y,
  input  logic                       in_cycle_button,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_is_sample,
  output logic [FREQ_W-1:0]          out_freq_now,
  output logic [WAVE_W-1:0]          out_waveform,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [FREQ_W-1:0]          cfg_data
);

  tgsc_cfg_t        cfg_r;
  logic             fifo_wr;
  tgsc_item_t       fifo_wr_item;
  logic             fifo_rd;
  tgsc_item_t       fifo_rd_item;
  logic             fifo_empty;
  logic [LVL_W-1:0] fifo_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_min <= FREQ_MIN_RESET;
      cfg_r.freq_max <= FREQ_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FREQ_MIN: cfg_r.freq_min <= cfg_data;
        CFG_FREQ_MAX: cfg_r.freq_max <= cfg_data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  tgsc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_stick_y      (in_stick_y),
    .in_cycle_button (in_cycle_button),
    .cfg             (cfg_r),
    .fifo_level      (fifo_level),
    .fifo_wr         (fifo_wr),
    .fifo_item       (fifo_wr_item)
  );

  tgsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fifo_wr),
    .wr_item (fifo_wr_item),
    .rd_en   (fifo_rd),
    .rd_item (fifo_rd_item),
    .empty   (fifo_empty),
    .level   (fifo_level)
  );

  tgsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_empty    (fifo_empty),
    .fifo_item     (fifo_rd_item),
    .fifo_rd       (fifo_rd),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_sample    (out_sample),
    .out_is_sample (out_is_sample),
    .out_freq_now  (out_freq_now),
    .out_waveform  (out_waveform)
  );

endmodule
